FILE: hw/rtl/tgi_pkg.sv
`default_nettype none

package tgi_pkg;

  // Grid dimensions in samples along each axis
  localparam int unsigned GRID_X = 16;
  localparam int unsigned GRID_Y = 16;
  localparam int unsigned GRID_Z = 16;
  localparam int unsigned GRID_DIM [3] = '{GRID_X, GRID_Y, GRID_Z};

  localparam int unsigned NUM_AXES  = 3;
  localparam int unsigned IDX_W     = 4;
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned FRAC_W    = 16;
  localparam int unsigned WGT_W     = FRAC_W + 1;
  localparam int unsigned TOL_W     = 16;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned FX_ONE    = 65536;

  // Grid memory split into eight banks by the parity of the three indexes
  localparam int unsigned NUM_BANKS  = 8;
  localparam int unsigned BANK_AW    = 3 * (IDX_W - 1);
  localparam int unsigned BANK_DEPTH = 1 << BANK_AW;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_X_ORIGIN = 3'd0,
    REG_Y_ORIGIN = 3'd1,
    REG_Z_ORIGIN = 3'd2,
    REG_X_SCALE  = 3'd3,
    REG_Y_SCALE  = 3'd4,
    REG_Z_SCALE  = 3'd5,
    REG_SNAP_TOL = 3'd6
  } cfg_reg_e;

  typedef enum logic {
    CMD_WRITE = 1'b0,
    CMD_QUERY = 1'b1
  } cmd_e;

  typedef struct packed {
    logic                     command;
    logic [IDX_W-1:0]         sample_x_index;
    logic [IDX_W-1:0]         sample_y_index;
    logic [IDX_W-1:0]         sample_z_index;
    logic signed [DATA_W-1:0] sample_value;
    logic signed [DATA_W-1:0] point_x;
    logic signed [DATA_W-1:0] point_y;
    logic signed [DATA_W-1:0] point_z;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] interpolated;
    logic                     out_of_grid;
  } out_item_t;

  // Sample write carried down to the memory stage
  typedef struct packed {
    logic                     command;
    logic [IDX_W-1:0]         x;
    logic [IDX_W-1:0]         y;
    logic [IDX_W-1:0]         z;
    logic signed [DATA_W-1:0] value;
  } wr_t;

  // Per-query side data carried alongside the blend
  typedef struct packed {
    logic [NUM_AXES-1:0][WGT_W-1:0] frac;
    logic                           flag;
  } meta_t;

endpackage

`default_nettype wire

FILE: hw/rtl/tgi_ifs.sv
`default_nettype none

interface tgi_in_if;
  logic              valid;
  logic              ready;
  tgi_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface tgi_out_if;
  logic               valid;
  logic               ready;
  tgi_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/trilinear_grid_interpolator.sv
// Pipeline: a query transfer passes through 14 register stages on the way to the output.
// Throughput: one item (sample write or query) per cycle while the output is not stalled;
// all eight corners are read at once from the eight parity banks of the grid memory.
// Reset: rst_ni clears the valid bits and loads the register defaults; grid memory
// is not cleared and an entry must be written before a query reads it.
`default_nettype none

module trilinear_grid_interpolator (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  tgi_in_if.sink                                  in_i,
  tgi_out_if.source                               out_o,
  input  wire logic                               cfg_we_i,
  input  wire logic [tgi_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  wire logic [tgi_pkg::DATA_W-1:0]         cfg_data_i
);

  localparam int unsigned NA = tgi_pkg::NUM_AXES;
  localparam int unsigned DW = tgi_pkg::DATA_W;
  localparam int unsigned WW = tgi_pkg::WGT_W;
  localparam int unsigned IW = tgi_pkg::IDX_W;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic signed [DW-1:0]          origin_q [NA];
  logic [DW-1:0]                 scale_q  [NA];
  logic [tgi_pkg::TOL_W-1:0]     tol_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NA; k++) begin
        origin_q[k] <= '0;
        scale_q[k]  <= DW'(tgi_pkg::FX_ONE);
      end
      tol_q <= tgi_pkg::TOL_W'(1);
    end else if (cfg_we_i) begin
      unique case (tgi_pkg::cfg_reg_e'(cfg_idx_i))
        tgi_pkg::REG_X_ORIGIN: origin_q[0] <= cfg_data_i;
        tgi_pkg::REG_Y_ORIGIN: origin_q[1] <= cfg_data_i;
        tgi_pkg::REG_Z_ORIGIN: origin_q[2] <= cfg_data_i;
        tgi_pkg::REG_X_SCALE:  scale_q[0]  <= cfg_data_i;
        tgi_pkg::REG_Y_SCALE:  scale_q[1]  <= cfg_data_i;
        tgi_pkg::REG_Z_SCALE:  scale_q[2]  <= cfg_data_i;
        tgi_pkg::REG_SNAP_TOL: tol_q       <= cfg_data_i[tgi_pkg::TOL_W-1:0];
        default: ;  // drop writes past the register list
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Pipeline control: the whole pipe advances together. The output register
  // is the last stage, so a new transfer is taken whenever the result there
  // is gone or is being taken this cycle.
  // ---------------------------------------------------------------------------
  logic advance;
  logic vld_q [1:14];

  assign advance     = !vld_q[14] || out_o.ready;
  assign in_i.ready  = advance;

  tgi_pkg::wr_t wr_q [1:4];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 1; s <= 14; s++) vld_q[s] <= 1'b0;
    end else if (advance) begin
      vld_q[1] <= in_i.valid;
      for (int s = 2; s <= 4; s++) vld_q[s] <= vld_q[s-1];
      // sample writes end at the memory stage and give no result
      vld_q[5] <= vld_q[4] && (wr_q[4].command == tgi_pkg::CMD_QUERY);
      for (int s = 6; s <= 14; s++) vld_q[s] <= vld_q[s-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      wr_q[1] <= '{command: in_i.data.command,
                   x:       in_i.data.sample_x_index,
                   y:       in_i.data.sample_y_index,
                   z:       in_i.data.sample_z_index,
                   value:   in_i.data.sample_value};
      for (int s = 2; s <= 4; s++) wr_q[s] <= wr_q[s-1];
    end
  end

  // ---------------------------------------------------------------------------
  // Stages 1-4: map each coordinate onto the grid
  //   1: offset from origin, kept as sign and magnitude
  //   2: magnitude times scale (32x32)
  //   3: back to signed grid position in Q34.16, rounding toward minus infinity
  //   4: split into cell and fraction, snap near faces, clamp outside
  // ---------------------------------------------------------------------------
  logic signed [DW-1:0] point [NA];
  assign point[0] = in_i.data.point_x;
  assign point[1] = in_i.data.point_y;
  assign point[2] = in_i.data.point_z;

  logic              neg_q   [NA];
  logic [DW-1:0]     mag_q   [NA];
  logic              neg2_q  [NA];
  logic [2*DW-1:0]   prod_q  [NA];
  logic signed [49:0] pos_q  [NA];
  logic [IW-1:0]     idx_q   [NA];
  logic [WW-1:0]     frac_q  [NA];
  logic              flag_q  [NA];

  for (genvar k = 0; k < NA; k++) begin : g_axis
    localparam logic signed [33:0] LAST_CELL = 34'(tgi_pkg::GRID_DIM[k] - 1);
    localparam logic signed [33:0] MAX_CELL  = 34'(tgi_pkg::GRID_DIM[k] - 2);

    logic signed [DW:0] diff;
    logic signed [DW:0] mag;
    logic [2*DW:0]      rnd;
    logic signed [49:0] pos_d;
    logic signed [33:0] cell_pos;
    logic signed [33:0] cell_d;
    logic [WW-1:0]      frac_d;
    logic               flag_d;

    assign diff = {point[k][DW-1], point[k]} - {origin_q[k][DW-1], origin_q[k]};
    assign mag  = diff[DW] ? -diff : diff;

    assign rnd   = {1'b0, prod_q[k]} + (2*DW+1)'(tgi_pkg::FX_ONE - 1);
    assign pos_d = neg2_q[k] ? -$signed({1'b0, rnd[2*DW:16]})
                             : $signed({2'b00, prod_q[k][2*DW-1:16]});

    assign cell_pos = pos_q[k][49:16];

    always_comb begin
      cell_d = cell_pos;
      frac_d = {1'b0, pos_q[k][15:0]};
      flag_d = 1'b0;
      // left face: just below the first sample
      if (cell_pos == -34'sd1 &&
          (WW'(tgi_pkg::FX_ONE) - {1'b0, pos_q[k][15:0]}) <= WW'(tol_q)) begin
        cell_d = '0;
        frac_d = '0;
      end
      // right face: just past the last sample
      if (cell_d == LAST_CELL && frac_d <= WW'(tol_q)) begin
        cell_d = MAX_CELL;
        frac_d = WW'(tgi_pkg::FX_ONE);
      end
      if (cell_d < 0) begin
        cell_d = '0;
        frac_d = '0;
        flag_d = 1'b1;
      end else if (cell_d > MAX_CELL) begin
        cell_d = MAX_CELL;
        frac_d = WW'(tgi_pkg::FX_ONE);
        flag_d = 1'b1;
      end
    end

    always_ff @(posedge clk_i) begin
      if (advance) begin
        neg_q[k]  <= diff[DW];
        mag_q[k]  <= mag[DW-1:0];
        neg2_q[k] <= neg_q[k];
        prod_q[k] <= mag_q[k] * scale_q[k];
        pos_q[k]  <= pos_d;
        idx_q[k]  <= cell_d[IW-1:0];
        frac_q[k] <= frac_d;
        flag_q[k] <= flag_d;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 5: grid memory. Bank {x[0], y[0], z[0]} holds the samples of that
  // parity, so the eight corners of any cell sit in eight different banks.
  // Sample writes land here too, which keeps them in order with queries.
  // ---------------------------------------------------------------------------
  logic [DW-1:0] grid_mem_q [tgi_pkg::NUM_BANKS][tgi_pkg::BANK_DEPTH];
  logic [DW-1:0] rd_q       [tgi_pkg::NUM_BANKS];
  logic [tgi_pkg::BANK_AW-1:0] raddr [tgi_pkg::NUM_BANKS];
  logic [2:0]                  wbank;
  logic [tgi_pkg::BANK_AW-1:0] waddr;
  logic                        wen;

  always_comb begin
    logic [IW-1:0] cx, cy, cz;
    for (int b = 0; b < tgi_pkg::NUM_BANKS; b++) begin
      // pick whichever of cell and cell+1 has this bank's parity
      cx = (idx_q[0][0] == b[2]) ? idx_q[0] : idx_q[0] + IW'(1);
      cy = (idx_q[1][0] == b[1]) ? idx_q[1] : idx_q[1] + IW'(1);
      cz = (idx_q[2][0] == b[0]) ? idx_q[2] : idx_q[2] + IW'(1);
      raddr[b] = {cx[IW-1:1], cy[IW-1:1], cz[IW-1:1]};
    end
  end

  assign wbank = {wr_q[4].x[0], wr_q[4].y[0], wr_q[4].z[0]};
  assign waddr = {wr_q[4].x[IW-1:1], wr_q[4].y[IW-1:1], wr_q[4].z[IW-1:1]};
  assign wen   = advance && vld_q[4] && (wr_q[4].command == tgi_pkg::CMD_WRITE) &&
                 ({1'b0, wr_q[4].x} < (IW+1)'(tgi_pkg::GRID_X)) &&
                 ({1'b0, wr_q[4].y} < (IW+1)'(tgi_pkg::GRID_Y)) &&
                 ({1'b0, wr_q[4].z} < (IW+1)'(tgi_pkg::GRID_Z));

  always_ff @(posedge clk_i) begin
    if (wen) begin
      grid_mem_q[wbank][waddr] <= wr_q[4].value;
    end
    if (advance) begin
      for (int b = 0; b < tgi_pkg::NUM_BANKS; b++) rd_q[b] <= grid_mem_q[b][raddr[b]];
    end
  end

  // Side data: fractions and flag ride along stages 5-13
  tgi_pkg::meta_t meta_q [5:13];
  logic [2:0]     par_q;

  always_ff @(posedge clk_i) begin
    if (advance) begin
      for (int k = 0; k < NA; k++) meta_q[5].frac[k] <= frac_q[k];
      meta_q[5].flag <= flag_q[0] || flag_q[1] || flag_q[2];
      par_q          <= {idx_q[0][0], idx_q[1][0], idx_q[2][0]};
      for (int s = 6; s <= 13; s++) meta_q[s] <= meta_q[s-1];
    end
  end

  // ---------------------------------------------------------------------------
  // Stages 6-14: three lerp levels (z, then y, then x), each as
  //   difference -> multiply by fraction -> add base and round
  // lerp(a, b, f) = floor((a * 2^16 + (b - a) * f + 2^15) / 2^16)
  // ---------------------------------------------------------------------------
  function automatic logic signed [34:0] lerp_round(input logic signed [DW-1:0] a,
                                                    input logic signed [50:0] p);
    logic signed [50:0] sum;
    sum = ($signed(51'(a)) <<< 16) + p + 51'sd32768;
    return sum[50:16];
  endfunction

  logic signed [DW:0]   dz_q  [4];
  logic signed [DW-1:0] az_q  [4];
  logic signed [50:0]   pz_q  [4];
  logic signed [DW-1:0] az7_q [4];
  logic signed [DW-1:0] zy_q  [4];
  logic signed [DW:0]   dy_q  [2];
  logic signed [DW-1:0] ay_q  [2];
  logic signed [50:0]   py_q  [2];
  logic signed [DW-1:0] ay10_q[2];
  logic signed [DW-1:0] yx_q  [2];
  logic signed [DW:0]   dx_q;
  logic signed [DW-1:0] ax_q;
  logic signed [50:0]   px_q;
  logic signed [DW-1:0] ax13_q;
  tgi_pkg::out_item_t   out_q;

  logic signed [DW-1:0] corner_lo [4];
  logic signed [DW-1:0] corner_hi [4];
  logic signed [34:0]   blend;
  logic signed [DW-1:0] blend_sat;

  // route bank outputs back to corner order (x offset a, y offset b, z offset c)
  always_comb begin
    for (int j = 0; j < 4; j++) begin
      corner_lo[j] = rd_q[{par_q[2] ^ j[1], par_q[1] ^ j[0], par_q[0]}];
      corner_hi[j] = rd_q[{par_q[2] ^ j[1], par_q[1] ^ j[0], ~par_q[0]}];
    end
  end

  assign blend = lerp_round(ax13_q, px_q);

  always_comb begin
    if (blend > 35'sd2147483647) begin
      blend_sat = {1'b0, {(DW-1){1'b1}}};
    end else if (blend < -35'sd2147483648) begin
      blend_sat = {1'b1, {(DW-1){1'b0}}};
    end else begin
      blend_sat = blend[DW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      for (int j = 0; j < 4; j++) begin
        dz_q[j]  <= {corner_hi[j][DW-1], corner_hi[j]} - {corner_lo[j][DW-1], corner_lo[j]};
        az_q[j]  <= corner_lo[j];
        pz_q[j]  <= 51'(dz_q[j]) * 51'($signed({1'b0, meta_q[6].frac[2]}));
        az7_q[j] <= az_q[j];
        zy_q[j]  <= DW'(lerp_round(az7_q[j], pz_q[j]));
      end
      for (int a = 0; a < 2; a++) begin
        dy_q[a]   <= {zy_q[2*a+1][DW-1], zy_q[2*a+1]} - {zy_q[2*a][DW-1], zy_q[2*a]};
        ay_q[a]   <= zy_q[2*a];
        py_q[a]   <= 51'(dy_q[a]) * 51'($signed({1'b0, meta_q[9].frac[1]}));
        ay10_q[a] <= ay_q[a];
        yx_q[a]   <= DW'(lerp_round(ay10_q[a], py_q[a]));
      end
      dx_q   <= {yx_q[1][DW-1], yx_q[1]} - {yx_q[0][DW-1], yx_q[0]};
      ax_q   <= yx_q[0];
      px_q   <= 51'(dx_q) * 51'($signed({1'b0, meta_q[12].frac[0]}));
      ax13_q <= ax_q;
      out_q.interpolated <= blend_sat;
      out_q.out_of_grid  <= meta_q[13].flag;
    end
  end

  assign out_o.valid = vld_q[14];
  assign out_o.data  = out_q;

`ifndef SYNTHESIS
  // a sample write never reaches the blend stages
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && vld_q[4] && wr_q[4].command == tgi_pkg::CMD_WRITE) |=> !vld_q[5])
    else $error("sample write passed the memory stage as a query");

  // mapped x cell stays inside the grid with an x fraction of at most one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[5] |-> ($past(frac_q[0]) <= WW'(tgi_pkg::FX_ONE) &&
                  $past(idx_q[0]) <= IW'(tgi_pkg::GRID_X - 2)))
    else $error("x cell or fraction out of range");

  // a stalled pipe holds its result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q[14] && !advance) |=> (vld_q[14] && $stable(out_q)))
    else $error("result changed while stalled");

  // an accepted transfer enters stage 1
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && advance) |=> vld_q[1])
    else $error("accepted transfer lost at stage 1");
`endif

endmodule

`default_nettype wire

FILE: dv/tb_trilinear_grid_interpolator.sv
`timescale 1ns / 100ps

module tb_trilinear_grid_interpolator;

  localparam int CLK_HI    = 6;
  localparam int CLK_LO    = 6;
  localparam int DRAIN_CYC = 40;   // extra wait after the last owed result has come
  localparam int PHASE_LEN = 45;
  localparam int LONG_HOLD = 400;
  localparam int RETRIES   = 20;
  localparam longint ONE   = 65536;
  localparam int GRID_N    = tgi_pkg::GRID_X * tgi_pkg::GRID_Y * tgi_pkg::GRID_Z;

  // Samples loaded up front along each axis, and cells that queries aim at
  localparam int PRE_IDX  [6] = '{0, 1, 7, 8, 14, 15};
  localparam int MID_CELL [3] = '{0, 7, 14};

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                          cfg_we   = 1'b0;
  logic [tgi_pkg::CFG_IDX_W-1:0] cfg_idx  = '0;
  logic [tgi_pkg::DATA_W-1:0]    cfg_data = '0;

  tgi_in_if  in_if ();
  tgi_out_if out_if ();

  trilinear_grid_interpolator dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_if),
    .out_o      (out_if),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  always begin
    #CLK_HI clk_i = 1'b1;
    #CLK_LO clk_i = 1'b0;
  end

  // Mirror of the block: register file and grid samples
  longint             origin_m  [3];
  longint             scale_m   [3];
  longint             tol_m;
  logic signed [31:0] grid_m    [GRID_N];
  bit                 written_m [GRID_N];

  tgi_pkg::out_item_t blend_q [$];   // results still owed by the block
  int         errors;
  int         send_idle_pct;
  int         recv_idle_pct;
  int         hold_token;    // bump to ask the receiver for a long hold-off

  // Typed-in expectation travelling with the current directed row
  logic               row_typed  = 1'b0;
  logic signed [31:0] row_value  = '0;
  logic               row_flag   = 1'b0;

  typedef struct {
    tgi_pkg::in_item_t  item;
    bit                 typed;
    logic signed [31:0] value;
    bit                 flag;
  } stim_row_t;

  task automatic report(input string what, input longint got, input longint want);
    $display("[%0t] mismatch %s: got %h want %h", $time, what, got, want);
    errors++;
  endtask

  function automatic int grid_at(input longint x, input longint y, input longint z);
    return int'((x * tgi_pkg::GRID_Y + y) * tgi_pkg::GRID_Z + z);
  endfunction

  // Per-axis mapping of a coordinate to cell index and weight, with face snapping
  function automatic bit map_coord(input int axis, input logic signed [31:0] p,
                                   input longint n, output longint idx,
                                   output longint frac);
    longint     d;
    logic [63:0] mag;
    logic [63:0] prod;
    longint     pos;
    longint     i;
    longint     f;
    bit         clamped;
    d    = longint'(p) - origin_m[axis];
    mag  = (d < 0) ? -d : d;
    prod = mag * scale_m[axis];
    pos  = (d < 0) ? -longint'((prod + 64'd65535) >> 16) : longint'(prod >> 16);
    i    = pos >>> 16;
    f    = pos - i * ONE;
    clamped = 1'b0;
    if (i == -1 && (ONE - f) <= tol_m) begin
      i = 0;
      f = 0;
    end
    if (i == n - 1 && f <= tol_m) begin
      i = n - 2;
      f = ONE;
    end
    if (i < 0) begin
      i = 0;
      f = 0;
      clamped = 1'b1;
    end else if (i > n - 2) begin
      i = n - 2;
      f = ONE;
      clamped = 1'b1;
    end
    idx  = i;
    frac = f;
    return clamped;
  endfunction

  // Weighted mix, rounded to nearest with ties upward
  function automatic longint mix(input longint a, input longint b, input longint f);
    return (a * (ONE - f) + b * f + 32768) >>> 16;
  endfunction

  function automatic longint corner(input longint x, input longint y, input longint z);
    return longint'(grid_m[grid_at(x, y, z)]);
  endfunction

  // True when all eight corners of the query's cell hold a written sample
  function automatic bit corners_ok(input tgi_pkg::in_item_t it);
    longint ix, iy, iz, fx, fy, fz;
    bit     ok;
    void'(map_coord(0, it.point_x, tgi_pkg::GRID_X, ix, fx));
    void'(map_coord(1, it.point_y, tgi_pkg::GRID_Y, iy, fy));
    void'(map_coord(2, it.point_z, tgi_pkg::GRID_Z, iz, fz));
    ok = 1'b1;
    for (int a = 0; a < 2; a++)
      for (int b = 0; b < 2; b++)
        for (int c = 0; c < 2; c++)
          if (!written_m[grid_at(ix + a, iy + b, iz + c)]) ok = 1'b0;
    return ok;
  endfunction

  function automatic tgi_pkg::out_item_t blend_point(input tgi_pkg::in_item_t it);
    longint    ix, iy, iz, fx, fy, fz, r;
    longint    zy [2][2];
    longint    yx [2];
    bit        oob;
    tgi_pkg::out_item_t res;
    oob = map_coord(0, it.point_x, tgi_pkg::GRID_X, ix, fx);
    oob = map_coord(1, it.point_y, tgi_pkg::GRID_Y, iy, fy) || oob;
    oob = map_coord(2, it.point_z, tgi_pkg::GRID_Z, iz, fz) || oob;
    for (int a = 0; a < 2; a++)
      for (int b = 0; b < 2; b++)
        zy[a][b] = mix(corner(ix + a, iy + b, iz), corner(ix + a, iy + b, iz + 1), fz);
    for (int a = 0; a < 2; a++)
      yx[a] = mix(zy[a][0], zy[a][1], fy);
    r = mix(yx[0], yx[1], fx);
    if (r > 64'sd2147483647) r = 64'sd2147483647;
    if (r < -64'sd2147483648) r = -64'sd2147483648;
    res.interpolated = r[31:0];
    res.out_of_grid  = oob;
    return res;
  endfunction

  function automatic tgi_pkg::in_item_t mk_write(input int x, input int y, input int z,
                                                 input logic [31:0] v);
    tgi_pkg::in_item_t it;
    it = '0;
    it.command        = tgi_pkg::CMD_WRITE;
    it.sample_x_index = x[tgi_pkg::IDX_W-1:0];
    it.sample_y_index = y[tgi_pkg::IDX_W-1:0];
    it.sample_z_index = z[tgi_pkg::IDX_W-1:0];
    it.sample_value   = v;
    // junk in the unused point fields must not matter
    it.point_x = $urandom;
    it.point_y = $urandom;
    it.point_z = $urandom;
    return it;
  endfunction

  function automatic tgi_pkg::in_item_t mk_query(input logic [31:0] px,
                                                 input logic [31:0] py,
                                                 input logic [31:0] pz);
    tgi_pkg::in_item_t it;
    it = '0;
    it.command        = tgi_pkg::CMD_QUERY;
    it.sample_x_index = $urandom;
    it.sample_y_index = $urandom;
    it.sample_z_index = $urandom;
    it.sample_value   = $urandom;
    it.point_x = px;
    it.point_y = py;
    it.point_z = pz;
    return it;
  endfunction

  // Pick a coordinate that mostly lands on a loaded cell under the current setting
  function automatic logic [31:0] pick_coord(input int axis);
    longint t;
    int     k;
    k = $urandom_range(0, 99);
    if (k < 15) return $urandom;
    if (k < 30) begin
      // hug a face, inside or just outside the snap window
      t = ($urandom_range(0, 1) ? 0 : 15 * ONE) + longint'($urandom_range(0, 8)) - 4;
      if ($urandom_range(0, 1)) t = t + ($urandom_range(0, 1) ? tol_m : -tol_m);
    end else begin
      t = longint'(MID_CELL[$urandom_range(0, 2)]) * ONE +
          longint'($urandom_range(0, 65535));
    end
    if (scale_m[axis] == 0) return $urandom;
    return 32'(origin_m[axis] + (t * ONE) / scale_m[axis]);
  endfunction

  // Track every transfer into the block: mirror writes, predict queries
  always @(posedge clk_i) begin
    if (rst_ni && in_if.valid && in_if.ready) begin
      if (in_if.data.command == tgi_pkg::CMD_WRITE) begin
        grid_m[grid_at(in_if.data.sample_x_index, in_if.data.sample_y_index,
                       in_if.data.sample_z_index)] = in_if.data.sample_value;
        written_m[grid_at(in_if.data.sample_x_index, in_if.data.sample_y_index,
                          in_if.data.sample_z_index)] = 1'b1;
      end else if (row_typed) begin
        blend_q.push_back('{interpolated: row_value, out_of_grid: row_flag});
      end else begin
        blend_q.push_back(blend_point(in_if.data));
      end
    end
  end

  // Compare every result transfer against the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (blend_q.size() == 0) begin
        report("unexpected result", out_if.data.interpolated, 0);
      end else begin
        if (out_if.data.interpolated !== blend_q[0].interpolated)
          report("interpolated", out_if.data.interpolated, blend_q[0].interpolated);
        if (out_if.data.out_of_grid !== blend_q[0].out_of_grid)
          report("out_of_grid", out_if.data.out_of_grid, blend_q[0].out_of_grid);
        void'(blend_q.pop_front());
      end
    end
  end

  // Receiver: random back-pressure plus an occasional long hold-off
  int hold_left = 0;
  int hold_seen = 0;
  always @(posedge clk_i) begin
    if (hold_token != hold_seen) begin
      hold_seen <= hold_token;
      hold_left <= LONG_HOLD;
      out_if.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Offer one item, idling first at random, and hold it until it transfers
  task automatic send(input tgi_pkg::in_item_t it, input bit typed = 0,
                      input logic [31:0] value = '0, input bit flag = 0);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(0, 99) < send_idle_pct);
    end
    in_if.valid <= 1'b1;
    in_if.data  <= it;
    row_typed   <= typed;
    row_value   <= value;
    row_flag    <= flag;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
  endtask

  // Drop valid and wait until every owed result has come, then let the pipe empty
  task automatic drain();
    in_if.valid <= 1'b0;
    row_typed   <= 1'b0;
    @(posedge clk_i);
    while (blend_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYC) @(posedge clk_i);
  endtask

  task automatic write_cfg(input tgi_pkg::cfg_reg_e idx, input logic [31:0] v);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= v;
    case (idx)
      tgi_pkg::REG_X_ORIGIN: origin_m[0] = longint'($signed(v));
      tgi_pkg::REG_Y_ORIGIN: origin_m[1] = longint'($signed(v));
      tgi_pkg::REG_Z_ORIGIN: origin_m[2] = longint'($signed(v));
      tgi_pkg::REG_X_SCALE:  scale_m[0]  = longint'(v);
      tgi_pkg::REG_Y_SCALE:  scale_m[1]  = longint'(v);
      tgi_pkg::REG_Z_SCALE:  scale_m[2]  = longint'(v);
      tgi_pkg::REG_SNAP_TOL: tol_m       = longint'(v[15:0]);
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic load_setting(input logic [31:0] ox, input logic [31:0] oy,
                              input logic [31:0] oz, input logic [31:0] sx,
                              input logic [31:0] sy, input logic [31:0] sz,
                              input logic [31:0] tol);
    write_cfg(tgi_pkg::REG_X_ORIGIN, ox);
    write_cfg(tgi_pkg::REG_Y_ORIGIN, oy);
    write_cfg(tgi_pkg::REG_Z_ORIGIN, oz);
    write_cfg(tgi_pkg::REG_X_SCALE, sx);
    write_cfg(tgi_pkg::REG_Y_SCALE, sy);
    write_cfg(tgi_pkg::REG_Z_SCALE, sz);
    write_cfg(tgi_pkg::REG_SNAP_TOL, tol);
    cfg_we <= 1'b0;
    @(posedge clk_i);
  endtask

  stim_row_t directed [$];

  initial begin
    tgi_pkg::in_item_t qry;
    int                tries;
    in_if.valid  = 1'b0;
    in_if.data   = '0;
    out_if.ready = 1'b0;
    errors       = 0;
    hold_token   = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    for (int k = 0; k < 3; k++) begin
      origin_m[k] = 0;
      scale_m[k]  = ONE;
    end
    tol_m = 1;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Grid memory starts undefined: load the samples around the cells that queries use
    for (int a = 0; a < 6; a++)
      for (int b = 0; b < 6; b++)
        for (int c = 0; c < 6; c++)
          send(mk_write(PRE_IDX[a], PRE_IDX[b], PRE_IDX[c], $urandom));

    // Directed rows at reset settings; corner values chosen so clamps read back plainly
    directed = '{
      '{mk_write(0, 0, 0, 32'h0001_2345), 0, '0, 0},
      '{mk_write(15, 15, 15, 32'h8000_0000), 0, '0, 0},
      '{mk_write(15, 0, 0, 32'h7fff_ffff), 0, '0, 0},
      '{mk_query(32'h8000_0000, 32'h8000_0000, 32'h8000_0000), 1, 32'h0001_2345, 1},
      '{mk_query(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff), 1, 32'h8000_0000, 1},
      '{mk_query(32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000), 1, 32'h7fff_ffff, 1},
      '{mk_query(32'h0, 32'h0, 32'h0), 1, 32'h0001_2345, 0},
      // left face snap on all three axes
      '{mk_query(-32'sd1, -32'sd1, -32'sd1), 1, 32'h0001_2345, 0},
      // right face snap on x, left on y and z
      '{mk_query(32'h000f_0001, -32'sd1, -32'sd1), 1, 32'h7fff_ffff, 0},
      '{mk_query(-32'sd2, 32'h0, 32'h0), 1, 32'h0001_2345, 1},
      '{mk_query(32'h000f_0002, 32'h0, 32'h0), 1, 32'h7fff_ffff, 1},
      '{mk_query(32'h0007_8000, 32'h0007_8000, 32'h0007_8000), 0, '0, 0},
      '{mk_query(32'h0000_4567, 32'h000e_ffff, 32'h0000_0001), 0, '0, 0},
      '{mk_write(7, 7, 7, 32'h0), 0, '0, 0},
      '{mk_write(8, 8, 8, 32'hffff_ffff), 0, '0, 0},
      '{mk_query(32'h0007_c000, 32'h0007_4000, 32'h0007_ffff), 0, '0, 0},
      '{mk_query(32'h0000_ffff, 32'h000e_0000, 32'h000f_0000), 0, '0, 0}
    };
    foreach (directed[k])
      send(directed[k].item, directed[k].typed, directed[k].value, directed[k].flag);
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: load_setting(32'h0, 32'h0, 32'h0, tgi_pkg::FX_ONE, tgi_pkg::FX_ONE,
                        tgi_pkg::FX_ONE, 1);
        1: load_setting(-32'sd229376, 32'h0002_0000, 32'h0, 32'h0002_0000, 32'h0000_8000,
                        tgi_pkg::FX_ONE, 0);
        2: load_setting(32'h8000_0000, 32'h7fff_ffff, 32'h0, tgi_pkg::FX_ONE,
                        tgi_pkg::FX_ONE, tgi_pkg::FX_ONE, 32'h0000_ffff);
        3: load_setting(32'h0001_0000, 32'hffff_0000, 32'h0, 32'h0, 32'hffff_ffff,
                        32'h0001_8000, 300);
        4: load_setting($urandom_range(0, 32'h0010_0000), -$urandom_range(0, 32'h0010_0000),
                        $urandom, tgi_pkg::FX_ONE, 32'h0000_c000, 32'h0001_4000, 12);
        default: load_setting(32'h0, 32'h0, 32'h0, tgi_pkg::FX_ONE, tgi_pkg::FX_ONE,
                              tgi_pkg::FX_ONE, 1);
      endcase
      // receiver lazy first, then sender lazy, then full speed
      send_idle_pct = (ph < 2) ? 11 : (ph < 4) ? 67 : 0;
      recv_idle_pct = (ph < 2) ? 67 : (ph < 4) ? 11 : 0;
      for (int n = 0; n < PHASE_LEN; n++) begin
        if (ph == 4 && n == 10) hold_token++;   // fill the pipe against a stalled output
        if (ph == 3 && n == PHASE_LEN / 2) drain();
        if ($urandom_range(0, 99) < 30) begin
          send(mk_write($urandom_range(0, 15), $urandom_range(0, 15), $urandom_range(0, 15),
                        $urandom));
        end else begin
          qry   = mk_query(pick_coord(0), pick_coord(1), pick_coord(2));
          tries = 0;
          while (!corners_ok(qry) && tries < RETRIES) begin
            qry = mk_query(pick_coord(0), pick_coord(1), pick_coord(2));
            tries++;
          end
          // fall back to a sample write when no loaded cell was hit
          if (corners_ok(qry))
            send(qry);
          else
            send(mk_write($urandom_range(0, 15), $urandom_range(0, 15),
                          $urandom_range(0, 15), $urandom));
        end
      end
      drain();
    end

    if (errors == 0 && blend_q.size() == 0) begin
      $display("tb_trilinear_grid_interpolator: PASS");
    end else begin
      $display("tb_trilinear_grid_interpolator: FAIL");
    end
    $finish;
  end

  initial begin
    #(12 * 500000);
    $display("tb_trilinear_grid_interpolator: FAIL");
    $finish;
  end

endmodule
